@@ rtl/eeg_pkg.sv @@
package eeg_pkg;

   localparam int CORDIC_STEPS = 30;
   localparam int RESULT_LIMIT = 16;
   localparam int VEC_W        = 33;
   localparam int ANG_W        = 32;
   localparam int LEN_W        = 32;
   localparam int ARM_W        = 4;
   localparam int ACC_W        = 40;
   localparam int COORD_W      = 18;

   localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 33'sd652032874;

   typedef enum logic [1:0] {
      REG_ARM_COUNT       = 2'd0,
      REG_BASE_LENGTH     = 2'd1,
      REG_BASE_PHASE_STEP = 2'd2
   } eeg_reg_type;

   // arm attributes that ride along the rotation chain
   typedef struct packed {
      logic             valid;
      logic [1:0]       quarter;
      logic [LEN_W-1:0] mag;
      logic             odd;
      logic [ARM_W-1:0] arm;
      logic             last;
   } eeg_tag_type;

   typedef struct packed {
      logic [VEC_W-1:0] x;
      logic [VEC_W-1:0] y;
      logic [ANG_W-1:0] z;
   } eeg_vec_type;

   // arctangent of 2^-k in 2^-32 turn
   function automatic logic [ANG_W-1:0] eeg_atan(input int k);
      logic [ANG_W-1:0] r;
      case (k)
         0:  r = 32'd536870912;
         1:  r = 32'd316933406;
         2:  r = 32'd167458907;
         3:  r = 32'd85004756;
         4:  r = 32'd42667331;
         5:  r = 32'd21354465;
         6:  r = 32'd10679838;
         7:  r = 32'd5340245;
         8:  r = 32'd2670163;
         9:  r = 32'd1335087;
         10: r = 32'd667544;
         11: r = 32'd333772;
         12: r = 32'd166886;
         13: r = 32'd83443;
         14: r = 32'd41722;
         15: r = 32'd20861;
         16: r = 32'd10430;
         17: r = 32'd5215;
         18: r = 32'd2608;
         19: r = 32'd1304;
         20: r = 32'd652;
         21: r = 32'd326;
         22: r = 32'd163;
         23: r = 32'd81;
         24: r = 32'd41;
         25: r = 32'd20;
         26: r = 32'd10;
         27: r = 32'd5;
         28: r = 32'd3;
         29: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/eeg_cordic_cell.sv @@
module eeg_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  eeg_pkg::eeg_tag_type tag_i,
   input  eeg_pkg::eeg_vec_type vec_i,
   output eeg_pkg::eeg_tag_type tag_o,
   output eeg_pkg::eeg_vec_type vec_o
);
   import eeg_pkg::*;

   eeg_tag_type tag_ff;
   eeg_vec_type vec_ff, vec_in;
   logic signed [VEC_W-1:0] dx, dy;

   always_comb begin
      dx = $signed(vec_i.y) >>> STEP;
      dy = $signed(vec_i.x) >>> STEP;
      if (!vec_i.z[ANG_W-1]) begin
         vec_in.x = vec_i.x - dx;
         vec_in.y = vec_i.y + dy;
         vec_in.z = vec_i.z - eeg_atan(STEP);
      end else begin
         vec_in.x = vec_i.x + dx;
         vec_in.y = vec_i.y - dy;
         vec_in.z = vec_i.z + eeg_atan(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else begin
         tag_ff.valid <= tag_i.valid;
      end
      tag_ff.quarter <= tag_i.quarter;
      tag_ff.mag     <= tag_i.mag;
      tag_ff.odd     <= tag_i.odd;
      tag_ff.arm     <= tag_i.arm;
      tag_ff.last    <= tag_i.last;
      vec_ff         <= vec_in;
   end

   assign tag_o = tag_ff;
   assign vec_o = vec_ff;

endmodule

@@ rtl/eeg_chain_sum.sv @@
module eeg_chain_sum (
   input  logic                          clock,
   input  logic                          reset,
   input  eeg_pkg::eeg_tag_type          tag_i,
   input  eeg_pkg::eeg_vec_type          vec_i,
   output logic                          rsp_valid,
   output logic [eeg_pkg::ARM_W-1:0]     rsp_arm_index,
   output logic signed [eeg_pkg::COORD_W-1:0] rsp_end_x,
   output logic signed [eeg_pkg::COORD_W-1:0] rsp_end_y,
   output logic                          rsp_last
);
   import eeg_pkg::*;

   localparam int PROD_W = 2 * VEC_W;
   localparam int OFF_W  = PROD_W - 30;

   // quadrant fix
   eeg_tag_type q_tag_ff;
   logic signed [VEC_W-1:0] q_c_ff, q_s_ff, q_c_in, q_s_in;
   // products
   eeg_tag_type m_tag_ff;
   logic signed [PROD_W-1:0] m_x_ff, m_y_ff;
   // rounded offsets
   eeg_tag_type o_tag_ff;
   logic signed [OFF_W-1:0] o_x_ff, o_y_ff;
   logic signed [PROD_W-1:0] o_xf, o_yf;
   // running sum
   eeg_tag_type a_tag_ff;
   logic signed [ACC_W-1:0] a_x_ff, a_y_ff, a_x_in, a_y_in;
   // output
   logic                     r_valid_ff;
   logic [ARM_W-1:0]         r_arm_ff;
   logic signed [COORD_W-1:0] r_x_ff, r_y_ff;
   logic                     r_last_ff;
   logic signed [ACC_W-1:0]  rx_sum, ry_sum;

   function automatic logic signed [COORD_W-1:0] sat(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-17:0] t;
      t = v[ACC_W-1:16];
      if (t > 24'sd131071)       return 18'sd131071;
      else if (t < -24'sd131072) return -18'sd131072;
      else                       return t[COORD_W-1:0];
   endfunction

   always_comb begin
      case (tag_i.quarter)
         2'd0: begin q_c_in = $signed(vec_i.x);  q_s_in = $signed(vec_i.y);  end
         2'd1: begin q_c_in = -$signed(vec_i.y); q_s_in = $signed(vec_i.x);  end
         2'd2: begin q_c_in = -$signed(vec_i.x); q_s_in = -$signed(vec_i.y); end
         default: begin q_c_in = $signed(vec_i.y); q_s_in = -$signed(vec_i.x); end
      endcase
   end

   always_comb begin
      // x offset is -len*sin, y offset is len*cos; odd arms carry a negative length
      o_xf = (m_tag_ff.odd ? m_x_ff : -m_x_ff) + (PROD_W'(1) <<< 29);
      o_yf = (m_tag_ff.odd ? -m_y_ff : m_y_ff) + (PROD_W'(1) <<< 29);
      a_x_in = (o_tag_ff.arm == '0 ? ACC_W'(0) : a_x_ff) + ACC_W'(o_x_ff);
      a_y_in = (o_tag_ff.arm == '0 ? ACC_W'(0) : a_y_ff) + ACC_W'(o_y_ff);
      rx_sum = a_x_ff + ACC_W'(32768);
      ry_sum = a_y_ff + ACC_W'(32768);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_tag_ff.valid <= 1'b0;
         m_tag_ff.valid <= 1'b0;
         o_tag_ff.valid <= 1'b0;
         a_tag_ff.valid <= 1'b0;
         r_valid_ff     <= 1'b0;
      end else begin
         q_tag_ff.valid <= tag_i.valid;
         m_tag_ff.valid <= q_tag_ff.valid;
         o_tag_ff.valid <= m_tag_ff.valid;
         a_tag_ff.valid <= o_tag_ff.valid;
         r_valid_ff     <= a_tag_ff.valid;
      end
      {q_tag_ff.quarter, q_tag_ff.mag, q_tag_ff.odd, q_tag_ff.arm, q_tag_ff.last} <=
         {tag_i.quarter, tag_i.mag, tag_i.odd, tag_i.arm, tag_i.last};
      {m_tag_ff.quarter, m_tag_ff.mag, m_tag_ff.odd, m_tag_ff.arm, m_tag_ff.last} <=
         {q_tag_ff.quarter, q_tag_ff.mag, q_tag_ff.odd, q_tag_ff.arm, q_tag_ff.last};
      {o_tag_ff.quarter, o_tag_ff.mag, o_tag_ff.odd, o_tag_ff.arm, o_tag_ff.last} <=
         {m_tag_ff.quarter, m_tag_ff.mag, m_tag_ff.odd, m_tag_ff.arm, m_tag_ff.last};
      {a_tag_ff.quarter, a_tag_ff.mag, a_tag_ff.odd, a_tag_ff.arm, a_tag_ff.last} <=
         {o_tag_ff.quarter, o_tag_ff.mag, o_tag_ff.odd, o_tag_ff.arm, o_tag_ff.last};
      q_c_ff <= q_c_in;
      q_s_ff <= q_s_in;
      m_x_ff <= $signed({1'b0, q_tag_ff.mag}) * q_s_ff;
      m_y_ff <= $signed({1'b0, q_tag_ff.mag}) * q_c_ff;
      o_x_ff <= o_xf[PROD_W-1:30];
      o_y_ff <= o_yf[PROD_W-1:30];
      if (o_tag_ff.valid) begin
         a_x_ff <= a_x_in;
         a_y_ff <= a_y_in;
      end
      r_arm_ff  <= a_tag_ff.arm;
      r_last_ff <= a_tag_ff.last;
      r_x_ff    <= sat(rx_sum);
      r_y_ff    <= sat(ry_sum);
   end

   assign rsp_valid     = r_valid_ff;
   assign rsp_arm_index = r_arm_ff;
   assign rsp_end_x     = r_x_ff;
   assign rsp_end_y     = r_y_ff;
   assign rsp_last      = r_last_ff;

endmodule

@@ rtl/epicycle_endpoint_generator.sv @@
// Epicycle endpoint generator. Pulse start with a frame index while busy is low; the block
// then streams one endpoint per arm on rsp_*, marked by rsp_valid for a single cycle each,
// arm 0 first and rsp_last on the final arm. The receiver cannot stall the stream, so take
// every strobe as it comes. On an idle block an accepted frame passes the pending slot,
// the arm sequencer, 30 CORDIC cells, then quadrant fix, multiply, rounding, running sum
// and output register before its first result is on the ports. A frame holds arm_count
// arms (1 to 16, 0 counting as 1), and a single-arm frame leaves a gap behind it: the arm
// sequencer feeds one rotation a cycle into a 30-cell CORDIC chain, and a new frame is
// taken while the previous one is still issuing, so frames of two or more arms follow
// each other with no gap. Write the configuration only while no frame is in flight.
module epicycle_endpoint_generator #(
   parameter int MAX_ARMS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [31:0]                        req_frame_index,
   output logic                               rsp_valid,
   output logic [eeg_pkg::ARM_W-1:0]          rsp_arm_index,
   output logic signed [eeg_pkg::COORD_W-1:0] rsp_end_x,
   output logic signed [eeg_pkg::COORD_W-1:0] rsp_end_y,
   output logic                               rsp_last,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [31:0]                        csr_data
);
   import eeg_pkg::*;

   localparam int LIMIT = (MAX_ARMS < RESULT_LIMIT) ? MAX_ARMS : RESULT_LIMIT;

   // configuration
   logic [4:0]  arm_count_ff;
   logic [15:0] base_length_ff;
   logic [31:0] base_step_ff;

   // frame waiting for the sequencer
   logic        pend_ff;
   logic [31:0] frame_ff;

   // arm sequencer
   logic             seq_active_ff;
   logic [ARM_W-1:0] seq_arm_ff;
   logic [31:0]      seq_shift_ff, seq_total_ff;
   logic [LEN_W-1:0] seq_len_ff;
   logic [4:0]       count;
   logic             seq_last, seq_load, accept;
   logic [31:0]      phase;

   eeg_tag_type tag_chain [CORDIC_STEPS+1];
   eeg_vec_type vec_chain [CORDIC_STEPS+1];

   always_comb begin
      if (arm_count_ff == 5'd0)              count = 5'd1;
      else if (arm_count_ff > 5'(LIMIT))     count = 5'(LIMIT);
      else                                   count = arm_count_ff;
   end

   assign accept   = start && !busy;
   assign busy     = pend_ff;
   assign seq_last = seq_active_ff && ({1'b0, seq_arm_ff} == count - 5'd1);
   assign seq_load = pend_ff && (!seq_active_ff || seq_last);
   // running phase of this arm: sum of all arm phases up to it, wrapping a full turn
   assign phase    = seq_total_ff + seq_shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_count_ff   <= 5'd10;
         base_length_ff <= 16'd51200;
         base_step_ff   <= 32'd341783;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ARM_COUNT:       arm_count_ff   <= csr_data[4:0];
            REG_BASE_LENGTH:     base_length_ff <= csr_data[15:0];
            REG_BASE_PHASE_STEP: base_step_ff   <= csr_data;
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= 1'b0;
         seq_active_ff <= 1'b0;
      end else begin
         if (accept)        pend_ff <= 1'b1;
         else if (seq_load) pend_ff <= 1'b0;
         if (seq_load)      seq_active_ff <= 1'b1;
         else if (seq_last) seq_active_ff <= 1'b0;
      end
      if (accept) frame_ff <= req_frame_index;
      if (seq_load) begin
         // arm i turns by (step << i) * frame, which is (step * frame) << i
         seq_shift_ff <= 32'(base_step_ff * frame_ff);
         seq_total_ff <= 32'd0;
         seq_len_ff   <= {base_length_ff, 16'd0};
         seq_arm_ff   <= '0;
      end else begin
         // advance to the next arm: double the step, halve the length
         seq_shift_ff <= {seq_shift_ff[30:0], 1'b0};
         seq_total_ff <= phase;
         seq_len_ff   <= {1'b0, seq_len_ff[LEN_W-1:1]};
         seq_arm_ff   <= seq_arm_ff + ARM_W'(1);
      end
   end

   // feed the head of the rotation chain
   always_comb begin
      tag_chain[0].valid   = seq_active_ff;
      tag_chain[0].quarter = phase[31:30];
      tag_chain[0].mag     = seq_len_ff;
      tag_chain[0].odd     = seq_arm_ff[0];
      tag_chain[0].arm     = seq_arm_ff;
      tag_chain[0].last    = seq_last;
      vec_chain[0].x       = CORDIC_GAIN;
      vec_chain[0].y       = '0;
      vec_chain[0].z       = {2'b00, phase[29:0]};
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
      eeg_cordic_cell #(.STEP(k)) u_cell (
         .clock (clock),
         .reset (reset),
         .tag_i (tag_chain[k]),
         .vec_i (vec_chain[k]),
         .tag_o (tag_chain[k+1]),
         .vec_o (vec_chain[k+1])
      );
   end

   eeg_chain_sum u_sum (
      .clock         (clock),
      .reset         (reset),
      .tag_i         (tag_chain[CORDIC_STEPS]),
      .vec_i         (vec_chain[CORDIC_STEPS]),
      .rsp_valid     (rsp_valid),
      .rsp_arm_index (rsp_arm_index),
      .rsp_end_x     (rsp_end_x),
      .rsp_end_y     (rsp_end_y),
      .rsp_last      (rsp_last)
   );

endmodule
